// ===== src/brfs_pkg.sv =====
// ----------------------------------------------------------------------------
// brfs_pkg
// Shared types, constants and ring arithmetic of the byte ring FIFO.
// ----------------------------------------------------------------------------
package brfs_pkg;

  localparam int CAPACITY    = 1024;
  localparam int PATTERN_MAX = 8;
  localparam int QDEPTH      = 2;

  localparam int PTR_W  = $clog2(CAPACITY);
  localparam int LEN_W  = 11;
  localparam int PLEN_W = 4;
  localparam int PAT_W  = 8 * PATTERN_MAX;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [3:0] CMD_PUSH   = 4'd0;
  localparam logic [3:0] CMD_POP    = 4'd1;
  localparam logic [3:0] CMD_POPW   = 4'd2;
  localparam logic [3:0] CMD_PEEK   = 4'd3;
  localparam logic [3:0] CMD_PEEKW  = 4'd4;
  localparam logic [3:0] CMD_SKIP   = 4'd5;
  localparam logic [3:0] CMD_REWIND = 4'd6;
  localparam logic [3:0] CMD_CLEAR  = 4'd7;
  localparam logic [3:0] CMD_FIND   = 4'd8;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_FULL     = 3'd1;
  localparam logic [2:0] ST_EMPTY    = 3'd2;
  localparam logic [2:0] ST_SHORT    = 3'd3;
  localparam logic [2:0] ST_NOTFOUND = 3'd4;

  localparam logic [1:0] REG_LOW_FILL = 2'd0;
  localparam logic [1:0] REG_PATTERN  = 2'd1;
  localparam logic [1:0] REG_PAT_LEN  = 2'd2;

  typedef enum logic [3:0] {
    OP_PUSH, OP_POP, OP_POPW, OP_PEEK, OP_PEEKW,
    OP_SKIP, OP_REWIND, OP_CLEAR, OP_FIND, OP_NOP
  } op_t;

  typedef enum logic [2:0] {
    BK_IDLE, BK_RD_LO, BK_RD_HI, BK_SCAN, BK_FIN
  } bk_state_t;

  typedef struct packed {
    op_t               op;
    logic [7:0]        data;
    logic [LEN_W-1:0]  amount;
  } item_t;

  typedef struct packed {
    logic [LEN_W-1:0]  low_fill_level;
    logic [63:0]       search_pattern;
    logic [PLEN_W-1:0] pattern_length;
  } cfg_t;

  // (base + off) mod CAPACITY, valid for base + off < 2*CAPACITY
  function automatic logic [PTR_W-1:0] ring_add(logic [PTR_W-1:0] base,
                                                logic [LEN_W-1:0] off);
    logic [LEN_W:0] s;
    s = {{(LEN_W+1-PTR_W){1'b0}}, base} + {1'b0, off};
    if (s >= (LEN_W+1)'(CAPACITY)) begin
      s = s - (LEN_W+1)'(CAPACITY);
    end
    return s[PTR_W-1:0];
  endfunction

  // (base - off) mod CAPACITY, valid for off <= CAPACITY
  function automatic logic [PTR_W-1:0] ring_sub(logic [PTR_W-1:0] base,
                                                logic [LEN_W-1:0] off);
    logic [LEN_W:0] s;
    s = {{(LEN_W+1-PTR_W){1'b0}}, base} + (LEN_W+1)'(CAPACITY) - {1'b0, off};
    if (s >= (LEN_W+1)'(CAPACITY)) begin
      s = s - (LEN_W+1)'(CAPACITY);
    end
    return s[PTR_W-1:0];
  endfunction

endpackage

// ===== src/brfs_front.sv =====
// ----------------------------------------------------------------------------
// brfs_front
// Input register: accepts items and decodes the command into an operation.
// ----------------------------------------------------------------------------
module brfs_front
  import brfs_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [3:0]       in_cmd,
  input  logic [7:0]       in_data_in,
  input  logic [LEN_W-1:0] in_amount,
  output logic             q_push,
  output item_t            q_item,
  input  logic             q_ready
);

  logic  fe_vld_r, fe_vld_nxt;
  item_t fe_item_r, fe_item_nxt;
  logic  accept;
  op_t   dec_op;

  always_comb begin
    case (in_cmd)
      CMD_PUSH:   dec_op = OP_PUSH;
      CMD_POP:    dec_op = OP_POP;
      CMD_POPW:   dec_op = OP_POPW;
      CMD_PEEK:   dec_op = OP_PEEK;
      CMD_PEEKW:  dec_op = OP_PEEKW;
      CMD_SKIP:   dec_op = OP_SKIP;
      CMD_REWIND: dec_op = OP_REWIND;
      CMD_CLEAR:  dec_op = OP_CLEAR;
      CMD_FIND:   dec_op = OP_FIND;
      default:    dec_op = OP_NOP;
    endcase
  end

  assign in_stall = fe_vld_r && !q_ready;
  assign accept   = in_valid && !in_stall;
  assign q_push   = fe_vld_r;
  assign q_item   = fe_item_r;

  always_comb begin
    fe_vld_nxt  = fe_vld_r;
    fe_item_nxt = fe_item_r;
    if (accept) begin
      fe_vld_nxt         = 1'b1;
      fe_item_nxt.op     = dec_op;
      fe_item_nxt.data   = in_data_in;
      fe_item_nxt.amount = in_amount;
    end else if (q_ready) begin
      fe_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fe_vld_r <= 1'b0;
    end else begin
      fe_vld_r <= fe_vld_nxt;
    end
    fe_item_r <= fe_item_nxt;
  end

endmodule

// ===== src/brfs_queue.sv =====
// ----------------------------------------------------------------------------
// brfs_queue
// Short item queue between the front and the back.
// ----------------------------------------------------------------------------
module brfs_queue
  import brfs_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  item_t push_item,
  output logic  push_ready,
  output logic  pop_valid,
  output item_t pop_item,
  input  logic  pop
);

  item_t              entry_r [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]  cnt_r, cnt_nxt;
  logic               do_push, do_pop;

  assign push_ready = (cnt_r != QCNT_W'(QDEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_item   = entry_r[rd_ptr_r];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + QCNT_W'(1);
    end else if (!do_push && do_pop) begin
      cnt_nxt = cnt_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ===== src/brfs_back.sv =====
// ----------------------------------------------------------------------------
// brfs_back
// Executes one item at a time on the ring store and holds the result.
// ----------------------------------------------------------------------------
module brfs_back
  import brfs_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_valid,
  input  item_t            q_item,
  output logic             q_pop,
  input  cfg_t             cfg,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [2:0]       out_status,
  output logic [15:0]      out_data_out,
  output logic [LEN_W-1:0] out_fill_length,
  output logic [LEN_W-1:0] out_free_space,
  output logic             out_low_fill,
  output logic [LEN_W-1:0] out_match_end
);

  logic [7:0] mem [CAPACITY];
  logic [7:0] rd_data_r;
  logic             mem_we;
  logic [PTR_W-1:0] mem_wa, mem_ra;

  bk_state_t        state_r, state_nxt;
  logic [LEN_W-1:0] fill_r, fill_nxt;
  logic [PTR_W-1:0] front_r, front_nxt;
  logic [2:0]       res_status_r, res_status_nxt;
  logic [15:0]      res_data_r, res_data_nxt;
  logic [LEN_W-1:0] res_mend_r, res_mend_nxt;
  logic [PTR_W-1:0] rd_addr_r, rd_addr_nxt;
  logic             word_r, word_nxt;
  logic [LEN_W-1:0] iss_r, iss_nxt;
  logic [LEN_W-1:0] rcv_r, rcv_nxt;
  logic             rvld_r, rvld_nxt;
  logic [PAT_W-1:0] win_r, win_nxt, win_new;
  logic [PAT_W-1:0] pat_al_r, pat_al_nxt;
  logic [PAT_W-1:0] mask_r, mask_nxt;
  logic [PLEN_W-1:0] len_r, len_nxt, eff_len, sh_bytes;
  logic [LEN_W-1:0] rcv_p1;
  logic [LEN_W:0]   amt_p1, amt_p2;
  logic [LEN_W-1:0] free_now;

  logic             out_valid_r, out_valid_nxt;
  logic [2:0]       out_status_r;
  logic [15:0]      out_data_r;
  logic [LEN_W-1:0] out_fill_r, out_free_r, out_mend_r;
  logic             out_low_r;
  logic             out_load;

  always_comb begin
    if (cfg.pattern_length == '0) begin
      eff_len = PLEN_W'(1);
    end else if (cfg.pattern_length > PLEN_W'(PATTERN_MAX)) begin
      eff_len = PLEN_W'(PATTERN_MAX);
    end else begin
      eff_len = cfg.pattern_length;
    end
  end

  assign sh_bytes = PLEN_W'(PATTERN_MAX) - eff_len;
  assign rcv_p1   = rcv_r + LEN_W'(1);
  assign win_new  = {rd_data_r, win_r[PAT_W-1:8]};
  assign amt_p1   = {1'b0, q_item.amount} + (LEN_W+1)'(1);
  assign amt_p2   = {1'b0, q_item.amount} + (LEN_W+1)'(2);
  assign free_now = LEN_W'(CAPACITY) - fill_r;

  always_comb begin
    state_nxt      = state_r;
    fill_nxt       = fill_r;
    front_nxt      = front_r;
    res_status_nxt = res_status_r;
    res_data_nxt   = res_data_r;
    res_mend_nxt   = res_mend_r;
    rd_addr_nxt    = rd_addr_r;
    word_nxt       = word_r;
    iss_nxt        = iss_r;
    rcv_nxt        = rcv_r;
    rvld_nxt       = 1'b0;
    win_nxt        = win_r;
    pat_al_nxt     = pat_al_r;
    mask_nxt       = mask_r;
    len_nxt        = len_r;
    q_pop          = 1'b0;
    mem_we         = 1'b0;
    mem_wa         = ring_add(front_r, fill_r);
    mem_ra         = front_r;
    out_load       = 1'b0;

    case (state_r)
      BK_IDLE: begin
        if (q_valid) begin
          q_pop          = 1'b1;
          res_status_nxt = ST_OK;
          res_data_nxt   = '0;
          res_mend_nxt   = '0;
          state_nxt      = BK_FIN;
          case (q_item.op)
            OP_PUSH: begin
              if (fill_r >= LEN_W'(CAPACITY)) begin
                res_status_nxt = ST_FULL;
              end else begin
                mem_we   = 1'b1;
                fill_nxt = fill_r + LEN_W'(1);
              end
            end
            OP_POP: begin
              if (fill_r == '0) begin
                res_status_nxt = ST_EMPTY;
              end else begin
                rd_addr_nxt = front_r;
                word_nxt    = 1'b0;
                front_nxt   = ring_add(front_r, LEN_W'(1));
                fill_nxt    = fill_r - LEN_W'(1);
                state_nxt   = BK_RD_LO;
              end
            end
            OP_POPW: begin
              if (fill_r == '0) begin
                res_status_nxt = ST_EMPTY;
              end else if (fill_r < LEN_W'(2)) begin
                res_status_nxt = ST_SHORT;
              end else begin
                rd_addr_nxt = front_r;
                word_nxt    = 1'b1;
                front_nxt   = ring_add(front_r, LEN_W'(2));
                fill_nxt    = fill_r - LEN_W'(2);
                state_nxt   = BK_RD_LO;
              end
            end
            OP_PEEK: begin
              if (fill_r == '0) begin
                res_status_nxt = ST_EMPTY;
              end else if (amt_p1 > {1'b0, fill_r}) begin
                res_status_nxt = ST_SHORT;
              end else begin
                mem_ra      = ring_add(front_r, q_item.amount);
                rd_addr_nxt = mem_ra;
                word_nxt    = 1'b0;
                state_nxt   = BK_RD_LO;
              end
            end
            OP_PEEKW: begin
              if (fill_r == '0) begin
                res_status_nxt = ST_EMPTY;
              end else if (amt_p2 > {1'b0, fill_r}) begin
                res_status_nxt = ST_SHORT;
              end else begin
                mem_ra      = ring_add(front_r, q_item.amount);
                rd_addr_nxt = mem_ra;
                word_nxt    = 1'b1;
                state_nxt   = BK_RD_LO;
              end
            end
            OP_SKIP: begin
              if (q_item.amount >= fill_r) begin
                front_nxt = ring_add(front_r, fill_r);
                fill_nxt  = '0;
              end else begin
                front_nxt = ring_add(front_r, q_item.amount);
                fill_nxt  = fill_r - q_item.amount;
              end
            end
            OP_REWIND: begin
              if (q_item.amount > free_now) begin
                res_status_nxt = ST_FULL;
              end else begin
                front_nxt = ring_sub(front_r, q_item.amount);
                fill_nxt  = fill_r + q_item.amount;
              end
            end
            OP_CLEAR: begin
              front_nxt = '0;
              fill_nxt  = '0;
            end
            OP_FIND: begin
              if (fill_r < LEN_W'(eff_len)) begin
                res_status_nxt = ST_NOTFOUND;
              end else begin
                // pattern moved up so that its last byte sits at the newest window byte
                pat_al_nxt = cfg.search_pattern[PAT_W-1:0] << {sh_bytes, 3'b000};
                mask_nxt   = {PAT_W{1'b1}} << {sh_bytes, 3'b000};
                len_nxt    = eff_len;
                iss_nxt    = '0;
                rcv_nxt    = '0;
                win_nxt    = '0;
                state_nxt  = BK_SCAN;
              end
            end
            default: begin
            end
          endcase
        end
      end
      BK_RD_LO: begin
        res_data_nxt = {8'h00, rd_data_r};
        if (word_r) begin
          mem_ra    = ring_add(rd_addr_r, LEN_W'(1));
          state_nxt = BK_RD_HI;
        end else begin
          state_nxt = BK_FIN;
        end
      end
      BK_RD_HI: begin
        res_data_nxt = {rd_data_r, res_data_r[7:0]};
        state_nxt    = BK_FIN;
      end
      BK_SCAN: begin
        if (iss_r < fill_r) begin
          mem_ra   = ring_add(front_r, iss_r);
          iss_nxt  = iss_r + LEN_W'(1);
          rvld_nxt = 1'b1;
        end
        if (rvld_r) begin
          win_nxt = win_new;
          rcv_nxt = rcv_p1;
          if ((rcv_p1 >= LEN_W'(len_r)) && (((win_new ^ pat_al_r) & mask_r) == '0)) begin
            res_status_nxt = ST_OK;
            res_mend_nxt   = rcv_p1;
            state_nxt      = BK_FIN;
          end else if (rcv_p1 == fill_r) begin
            res_status_nxt = ST_NOTFOUND;
            res_mend_nxt   = '0;
            state_nxt      = BK_FIN;
          end
        end
      end
      BK_FIN: begin
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = BK_IDLE;
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= q_item.data;
    end
    rd_data_r <= mem[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      fill_r      <= '0;
      front_r     <= '0;
      rvld_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      front_r     <= front_nxt;
      rvld_r      <= rvld_nxt;
      out_valid_r <= out_valid_nxt;
    end
    res_status_r <= res_status_nxt;
    res_data_r   <= res_data_nxt;
    res_mend_r   <= res_mend_nxt;
    rd_addr_r    <= rd_addr_nxt;
    word_r       <= word_nxt;
    iss_r        <= iss_nxt;
    rcv_r        <= rcv_nxt;
    win_r        <= win_nxt;
    pat_al_r     <= pat_al_nxt;
    mask_r       <= mask_nxt;
    len_r        <= len_nxt;
    if (out_load) begin
      out_status_r <= res_status_r;
      out_data_r   <= res_data_r;
      out_fill_r   <= fill_r;
      out_free_r   <= free_now;
      out_low_r    <= (fill_r <= cfg.low_fill_level);
      out_mend_r   <= res_mend_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_data_out    = out_data_r;
  assign out_fill_length = out_fill_r;
  assign out_free_space  = out_free_r;
  assign out_low_fill    = out_low_r;
  assign out_match_end   = out_mend_r;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= LEN_W'(CAPACITY))
    else $error("fill count beyond capacity");

  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (state_r == BK_IDLE))
    else $error("queue popped while busy");

  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |=> (fill_r == $past(fill_r) + LEN_W'(1)))
    else $error("store write without fill increment");

  a_fill_free: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ({1'b0, out_fill_r} + {1'b0, out_free_r} == (LEN_W+1)'(CAPACITY)))
    else $error("fill and free space disagree");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r == ST_NOTFOUND)) |-> (out_mend_r == '0))
    else $error("match end set on a miss");

endmodule

// ===== src/byte_ring_fifo_with_search_core.sv =====
// An accepted item passes the front register and the item queue; the back end
// runs IDLE and FIN for push, skip, rewind and clear, adds RD_LO for a byte pop or
// peek and RD_HI too for a word, and scans in BK_SCAN for a find, one held byte
// per cycle. While the back end is busy, new items wait in the front and queue.
// Reset (synchronous, active low) empties the FIFO and loads register defaults;
// the byte store itself is not cleared.
// ----------------------------------------------------------------------------
// byte_ring_fifo_with_search_core
// Byte ring FIFO with push, pop, peek, skip, rewind, clear and pattern search commands.
// ----------------------------------------------------------------------------
module byte_ring_fifo_with_search_core
  import brfs_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [3:0]       in_cmd,
  input  logic [7:0]       in_data_in,
  input  logic [LEN_W-1:0] in_amount,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [2:0]       out_status,
  output logic [15:0]      out_data_out,
  output logic [LEN_W-1:0] out_fill_length,
  output logic [LEN_W-1:0] out_free_space,
  output logic             out_low_fill,
  output logic [LEN_W-1:0] out_match_end,
  input  logic             cfg_psel,
  input  logic             cfg_penable,
  input  logic             cfg_pwrite,
  input  logic [4:0]       cfg_paddr,
  input  logic [63:0]      cfg_pwdata,
  output logic [63:0]      cfg_prdata,
  output logic             cfg_pready
);

  cfg_t       cfg_r;
  logic       cfg_wr;
  logic [1:0] reg_idx;

  logic  q_push, q_ready, q_valid, q_pop;
  item_t q_in_item, q_out_item;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign reg_idx    = cfg_paddr[4:3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.low_fill_level <= '0;
      cfg_r.search_pattern <= '0;
      cfg_r.pattern_length <= PLEN_W'(1);
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_LOW_FILL: cfg_r.low_fill_level <= cfg_pwdata[LEN_W-1:0];
        REG_PATTERN:  cfg_r.search_pattern <= cfg_pwdata;
        REG_PAT_LEN:  cfg_r.pattern_length <= cfg_pwdata[PLEN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_LOW_FILL: cfg_prdata = {{(64-LEN_W){1'b0}}, cfg_r.low_fill_level};
      REG_PATTERN:  cfg_prdata = cfg_r.search_pattern;
      REG_PAT_LEN:  cfg_prdata = {{(64-PLEN_W){1'b0}}, cfg_r.pattern_length};
      default:      cfg_prdata = '0;
    endcase
  end

  brfs_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_cmd     (in_cmd),
    .in_data_in (in_data_in),
    .in_amount  (in_amount),
    .q_push     (q_push),
    .q_item     (q_in_item),
    .q_ready    (q_ready)
  );

  brfs_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_item  (q_in_item),
    .push_ready (q_ready),
    .pop_valid  (q_valid),
    .pop_item   (q_out_item),
    .pop        (q_pop)
  );

  brfs_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_item          (q_out_item),
    .q_pop           (q_pop),
    .cfg             (cfg_r),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_data_out    (out_data_out),
    .out_fill_length (out_fill_length),
    .out_free_space  (out_free_space),
    .out_low_fill    (out_low_fill),
    .out_match_end   (out_match_end)
  );

endmodule

// ===== verif/tb_byte_ring_fifo_with_search_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_byte_ring_fifo_with_search_core
// Self-checking bench for the byte ring FIFO with pattern search. A short
// directed pass covers the empty, short and full cases of the commands. It is
// followed by random command streams under several register settings, with
// random idle bursts on the command side and stall bursts on the result side.
// Every result is checked against a behavioral FIFO kept in the bench.
// ----------------------------------------------------------------------------
module tb_byte_ring_fifo_with_search_core
  import brfs_pkg::*;
();

  localparam int          PHASE_ITEMS   = 230;
  localparam int          SETTLE_CYCLES = 16;
  localparam int          MAX_REPORTS   = 10;
  localparam int unsigned TIMEOUT_NS    = 50_000_000;

  typedef struct packed {
    logic [3:0]       cmd;
    logic [7:0]       data;
    logic [LEN_W-1:0] amount;
  } fifo_cmd_t;

  typedef struct packed {
    logic [2:0]       status;
    logic [15:0]      data_out;
    logic [LEN_W-1:0] fill_length;
    logic [LEN_W-1:0] free_space;
    logic             low_fill;
    logic [LEN_W-1:0] match_end;
  } fifo_result_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [3:0]       in_cmd = '0;
  logic [7:0]       in_data_in = '0;
  logic [LEN_W-1:0] in_amount = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [2:0]       out_status;
  logic [15:0]      out_data_out;
  logic [LEN_W-1:0] out_fill_length;
  logic [LEN_W-1:0] out_free_space;
  logic             out_low_fill;
  logic [LEN_W-1:0] out_match_end;
  logic             cfg_psel = 1'b0;
  logic             cfg_penable = 1'b0;
  logic             cfg_pwrite = 1'b0;
  logic [4:0]       cfg_paddr = '0;
  logic [63:0]      cfg_pwdata = '0;
  logic [63:0]      cfg_prdata;
  logic             cfg_pready;

  byte_ring_fifo_with_search_core DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_cmd          (in_cmd),
    .in_data_in      (in_data_in),
    .in_amount       (in_amount),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_data_out    (out_data_out),
    .out_fill_length (out_fill_length),
    .out_free_space  (out_free_space),
    .out_low_fill    (out_low_fill),
    .out_match_end   (out_match_end),
    .cfg_psel        (cfg_psel),
    .cfg_penable     (cfg_penable),
    .cfg_pwrite      (cfg_pwrite),
    .cfg_paddr       (cfg_paddr),
    .cfg_pwdata      (cfg_pwdata),
    .cfg_prdata      (cfg_prdata),
    .cfg_pready      (cfg_pready)
  );

  // bench copy of the FIFO and its registers
  logic [7:0]        ring_mem [CAPACITY];
  bit                ring_written [CAPACITY];
  int unsigned       ring_head = 0;
  int unsigned       ring_fill = 0;
  logic [LEN_W-1:0]  lf_level = '0;
  logic [63:0]       pat_bytes = '0;
  logic [PLEN_W-1:0] pat_len = 4'd1;

  fifo_cmd_t    pending_cmds [$];
  fifo_result_t expected_results [$];

  int unsigned mismatches = 0;
  int unsigned items_sent = 0;
  int unsigned n_accepted = 0;
  int unsigned n_results = 0;
  int unsigned n_settings = 0;
  int unsigned n_find_hits = 0;

  logic        in_fire = 1'b0;
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;
  int unsigned stretch_left = 0;
  bit          calm = 1'b0;
  bit          quiet = 1'b0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int unsigned pattern_span();
    if (pat_len == 0) return 1;
    if (pat_len > PATTERN_MAX) return PATTERN_MAX;
    return pat_len;
  endfunction

  function automatic logic [7:0] ring_byte(input int unsigned off);
    return ring_mem[(ring_head + off) % CAPACITY];
  endfunction

  function automatic bit bytes_known(input int unsigned off, input int unsigned n);
    int unsigned i;
    for (i = 0; i < n; i++) begin
      if (!ring_written[(ring_head + off + i) % CAPACITY]) return 1'b0;
    end
    return 1'b1;
  endfunction

  // held bytes behind the front that were written and can be rewound over
  function automatic int unsigned rewind_room();
    int unsigned k;
    k = 0;
    while (k < CAPACITY - ring_fill &&
           ring_written[(ring_head + CAPACITY - k - 1) % CAPACITY]) begin
      k++;
    end
    return k;
  endfunction

  function automatic bit reads_unknown(input logic [3:0] op, input logic [LEN_W-1:0] amount);
    int unsigned amt;
    amt = amount;
    case (op)
      CMD_POP:   return ring_fill >= 1 && !bytes_known(0, 1);
      CMD_POPW:  return ring_fill >= 2 && !bytes_known(0, 2);
      CMD_PEEK:  return amt + 1 <= ring_fill && !bytes_known(amt, 1);
      CMD_PEEKW: return amt + 2 <= ring_fill && !bytes_known(amt, 2);
      CMD_FIND:  return !bytes_known(0, ring_fill);
      default:   return 1'b0;
    endcase
  endfunction

  function automatic fifo_result_t apply_command(input logic [3:0] op, input logic [7:0] din,
                                                 input logic [LEN_W-1:0] amount);
    fifo_result_t r;
    int unsigned  amt, room, span, pos, k;
    bit           hit;
    r = '0;
    amt = amount;
    room = CAPACITY - ring_fill;
    case (op)
      CMD_PUSH: begin
        if (ring_fill >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          ring_mem[(ring_head + ring_fill) % CAPACITY] = din;
          ring_written[(ring_head + ring_fill) % CAPACITY] = 1'b1;
          ring_fill++;
        end
      end
      CMD_POP: begin
        if (ring_fill == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.data_out = {8'h00, ring_byte(0)};
          ring_head = (ring_head + 1) % CAPACITY;
          ring_fill--;
        end
      end
      CMD_POPW: begin
        if (ring_fill == 0) begin
          r.status = ST_EMPTY;
        end else if (ring_fill < 2) begin
          r.status = ST_SHORT;
        end else begin
          r.data_out = {ring_byte(1), ring_byte(0)};
          ring_head = (ring_head + 2) % CAPACITY;
          ring_fill -= 2;
        end
      end
      CMD_PEEK: begin
        if (ring_fill == 0) begin
          r.status = ST_EMPTY;
        end else if (amt + 1 > ring_fill) begin
          r.status = ST_SHORT;
        end else begin
          r.data_out = {8'h00, ring_byte(amt)};
        end
      end
      CMD_PEEKW: begin
        if (ring_fill == 0) begin
          r.status = ST_EMPTY;
        end else if (amt + 2 > ring_fill) begin
          r.status = ST_SHORT;
        end else begin
          r.data_out = {ring_byte(amt + 1), ring_byte(amt)};
        end
      end
      CMD_SKIP: begin
        if (amt >= ring_fill) begin
          ring_head = (ring_head + ring_fill) % CAPACITY;
          ring_fill = 0;
        end else begin
          ring_head = (ring_head + amt) % CAPACITY;
          ring_fill -= amt;
        end
      end
      CMD_REWIND: begin
        if (amt > room) begin
          r.status = ST_FULL;
        end else begin
          ring_head = (ring_head + CAPACITY - amt) % CAPACITY;
          ring_fill += amt;
        end
      end
      CMD_CLEAR: begin
        ring_head = 0;
        ring_fill = 0;
      end
      CMD_FIND: begin
        span = pattern_span();
        hit = 1'b0;
        for (pos = 0; !hit && pos + span <= ring_fill; pos++) begin
          hit = 1'b1;
          for (k = 0; k < span; k++) begin
            if (ring_byte(pos + k) != pat_bytes[8*k +: 8]) hit = 1'b0;
          end
          if (hit) r.match_end = LEN_W'(pos + span);
        end
        if (!hit) r.status = ST_NOTFOUND;
      end
      default: ;
    endcase
    r.fill_length = LEN_W'(ring_fill);
    r.free_space  = LEN_W'(CAPACITY - ring_fill);
    r.low_fill    = (ring_fill <= lf_level);
    return r;
  endfunction

  function automatic string show_result(input fifo_result_t r);
    return $sformatf("status=%0d data=%h fill=%0d free=%0d low=%0b match_end=%0d",
                     r.status, r.data_out, r.fill_length, r.free_space, r.low_fill,
                     r.match_end);
  endfunction

  task automatic report_error(input string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("ERROR: %s", msg);
  endtask

  // a read that would touch a never-written byte is turned into a push
  task automatic send(input logic [3:0] op, input logic [7:0] din,
                      input logic [LEN_W-1:0] amount);
    fifo_cmd_t    c;
    fifo_result_t r;
    if (reads_unknown(op, amount)) op = CMD_PUSH;
    r = apply_command(op, din, amount);
    if (op == CMD_FIND && r.status == ST_OK) n_find_hits++;
    c.cmd = op;
    c.data = din;
    c.amount = amount;
    pending_cmds.push_back(c);
    expected_results.push_back(r);
    items_sent++;
  endtask

  task automatic send_random();
    int unsigned      pick, span, k, bad, idx;
    logic [7:0]       b;
    logic [LEN_W-1:0] amt;
    span = pattern_span();
    pick = $urandom_range(0, 99);
    amt = LEN_W'($urandom_range(0, 2047));
    b = 8'($urandom);
    if (pick < 6) begin
      // the whole pattern, sometimes with one byte spoiled
      bad = ($urandom_range(0, 3) == 0) ? $urandom_range(0, span - 1) : span;
      for (k = 0; k < span; k++) begin
        send(CMD_PUSH, (k == bad) ? 8'($urandom) : pat_bytes[8*k +: 8], amt);
      end
    end else if (pick < 40) begin
      if ($urandom_range(0, 1) == 1) begin
        idx = $urandom_range(0, span - 1);
        b = pat_bytes[8*idx +: 8];
      end
      send(CMD_PUSH, b, amt);
    end else if (pick < 50) begin
      send(CMD_POP, b, amt);
    end else if (pick < 57) begin
      send(CMD_POPW, b, amt);
    end else if (pick < 65) begin
      if ($urandom_range(0, 4) != 0) amt = LEN_W'($urandom_range(0, ring_fill + 1));
      send(CMD_PEEK, b, amt);
    end else if (pick < 72) begin
      if ($urandom_range(0, 4) != 0) amt = LEN_W'($urandom_range(0, ring_fill + 1));
      send(CMD_PEEKW, b, amt);
    end else if (pick < 78) begin
      if ($urandom_range(0, 4) != 0) amt = LEN_W'($urandom_range(0, ring_fill / 4 + 2));
      send(CMD_SKIP, b, amt);
    end else if (pick < 84) begin
      case ($urandom_range(0, 9))
        0: ;
        1: amt = LEN_W'(CAPACITY - ring_fill);
        default: amt = LEN_W'($urandom_range(0, rewind_room()));
      endcase
      send(CMD_REWIND, b, amt);
    end else if (pick < 86) begin
      send(CMD_CLEAR, b, amt);
    end else if (pick < 96) begin
      send(CMD_FIND, b, amt);
    end else begin
      send(4'($urandom_range(9, 15)), b, amt);
    end
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [63:0] val);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 3'b000};
    cfg_pwdata  <= val;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    case (idx)
      REG_LOW_FILL: lf_level = val[LEN_W-1:0];
      REG_PATTERN:  pat_bytes = val;
      REG_PAT_LEN:  pat_len = val[PLEN_W-1:0];
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    while (pending_cmds.size() != 0 || expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(input logic [LEN_W-1:0] lf, input logic [63:0] pat,
                           input logic [PLEN_W-1:0] plen, input int unsigned count);
    int unsigned stop;
    wait_drained();
    cfg_write(REG_LOW_FILL, 64'(lf));
    cfg_write(REG_PATTERN, pat);
    cfg_write(REG_PAT_LEN, 64'(plen));
    n_settings++;
    stop = items_sent + count;
    while (items_sent < stop) send_random();
  endtask

  // item acceptance and result checking, sampled at the rising edge
  always @(posedge clk) begin : result_check
    fifo_result_t got, want;
    in_fire <= rst_n && in_valid && !in_stall;
    if (rst_n && in_valid && !in_stall) n_accepted++;
    if (rst_n && out_valid && !out_stall) begin
      got = {out_status, out_data_out, out_fill_length, out_free_space, out_low_fill,
             out_match_end};
      n_results++;
      if (expected_results.size() == 0) begin
        report_error($sformatf("unexpected result: %s", show_result(got)));
      end else begin
        want = expected_results.pop_front();
        if (got !== want) begin
          report_error($sformatf("result %0d: expected %s, got %s", n_results,
                                 show_result(want), show_result(got)));
        end
      end
    end
  end

  always @(negedge clk) begin : item_driver
    fifo_cmd_t item;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (gap_left != 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_cmds.size() != 0 && !quiet && !calm &&
                   $urandom_range(0, 7) == 0) begin
        in_valid <= 1'b0;
        gap_left <= $urandom_range(0, 9);
      end else if (pending_cmds.size() != 0) begin
        item = pending_cmds.pop_front();
        in_valid   <= 1'b1;
        in_cmd     <= item.cmd;
        in_data_in <= item.data;
        in_amount  <= item.amount;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin : stall_driver
    if (stretch_left == 0) begin
      stretch_left <= $urandom_range(50, 300);
      calm <= ($urandom_range(0, 2) == 0);
    end else begin
      stretch_left <= stretch_left - 1;
    end
    if (!rst_n || quiet || calm) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 11) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 9);
    end else begin
      out_stall <= 1'b0;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // empty FIFO, oversized rewind, unknown command
    send(CMD_POP, 8'h00, 11'd0);
    send(CMD_POPW, 8'h00, 11'd0);
    send(CMD_PEEK, 8'h00, 11'd0);
    send(CMD_PEEKW, 8'h00, 11'd0);
    send(CMD_FIND, 8'h00, 11'd0);
    send(CMD_SKIP, 8'h00, 11'd5);
    send(CMD_REWIND, 8'h00, 11'd2047);
    send(4'd15, 8'hFF, 11'd2047);
    // data extremes, single-byte find, short peeks and pops
    send(CMD_PUSH, 8'h00, 11'd0);
    send(CMD_FIND, 8'h00, 11'd0);
    send(CMD_PUSH, 8'hFF, 11'd0);
    send(CMD_PEEK, 8'h00, 11'd1);
    send(CMD_PEEKW, 8'h00, 11'd1);
    send(CMD_POPW, 8'h00, 11'd0);
    send(CMD_PUSH, 8'hA5, 11'd0);
    send(CMD_POPW, 8'h00, 11'd0);
    send(CMD_POP, 8'h00, 11'd0);
    send(CMD_REWIND, 8'h00, 11'd3);
    send(CMD_PEEKW, 8'h00, 11'd1);
    send(CMD_PEEK, 8'h00, 11'd2047);
    send(CMD_SKIP, 8'h00, 11'd2047);
    // rewind to full, push and rewind refused, clear
    send(CMD_REWIND, 8'h00, 11'd1024);
    send(CMD_PUSH, 8'h5A, 11'd0);
    send(CMD_REWIND, 8'h00, 11'd1);
    send(CMD_CLEAR, 8'h00, 11'd0);

    run_phase(11'd1024, {$urandom, $urandom}, 4'd0, PHASE_ITEMS);
    run_phase(11'd0, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8, PHASE_ITEMS);
    run_phase(11'd2047, 64'h5AC3_5A5A_C35A_5A5A, 4'd15, PHASE_ITEMS);
    run_phase(LEN_W'($urandom_range(0, 1024)), {$urandom, $urandom},
              PLEN_W'($urandom_range(2, 7)), PHASE_ITEMS);
    quiet = 1'b1;
    run_phase(LEN_W'($urandom_range(0, 64)), {16'($urandom), 16'($urandom), 32'($urandom)},
              4'd3, PHASE_ITEMS);
    wait_drained();

    $display("Checked %0d results of %0d commands over %0d register settings",
             n_results, n_accepted, n_settings + 1);
    $display("Pattern finds that matched: %0d, errors: %0d", n_find_hits, mismatches);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("Timeout with %0d results outstanding", expected_results.size());
    $display("Mismatches found");
    $finish;
  end

endmodule

// ===== files.f =====
src/brfs_pkg.sv
src/brfs_front.sv
src/brfs_queue.sv
src/brfs_back.sv
src/byte_ring_fifo_with_search_core.sv
verif/tb_byte_ring_fifo_with_search_core.sv
